// ----- rtl/xsf_pkg.sv -----
`timescale 1ns / 1ps
package xsf_pkg;

    localparam int unsigned SCREEN_COLUMNS = 64;
    localparam int unsigned SCREEN_ROWS    = 32;
    localparam int unsigned SPRITE_W       = 8;

    localparam int unsigned OP_W    = 2;
    localparam int unsigned COORD_W = 8;
    localparam int unsigned OFF_W   = 4;
    localparam int unsigned SUM_W   = COORD_W + 1;

    localparam int unsigned COL_AW = $clog2(SCREEN_COLUMNS);
    localparam int unsigned ROW_AW = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;

    // x mod columns through a reciprocal estimate plus one correction
    localparam int unsigned RECIP_SHIFT = 16;
    localparam int unsigned COL_RECIP   = (1 << RECIP_SHIFT) / SCREEN_COLUMNS;
    localparam int unsigned PROD_W      = COORD_W + RECIP_SHIFT;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2,
        OP_DRAW  = 2'd3
    } t_op;

    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

// ----- rtl/xsf_ctrl.sv -----
`timescale 1ns / 1ps
module xsf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    output xsf_pkg::t_cmd    o_cmd,
    input  xsf_pkg::t_status i_sts
);
    import xsf_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                // hold until the result register can take the transaction
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd.load = 1'b0;
        o_cmd.exec = 1'b0;
        o_stall    = 1'b1;
        case (r_state)
            S_IDLE: begin
                // no transaction is taken while reset is held
                o_stall    = !i_rst_n;
                o_cmd.load = i_valid && i_rst_n;
            end
            S_EXEC: begin
                o_cmd.exec = i_sts.out_free;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

endmodule

// ----- rtl/xsf_datapath.sv -----
`timescale 1ns / 1ps
module xsf_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  xsf_pkg::t_cmd                i_cmd,
    output xsf_pkg::t_status             o_sts,
    input  logic [xsf_pkg::OP_W-1:0]     i_op,
    input  logic [xsf_pkg::COORD_W-1:0]  i_x_pos,
    input  logic [xsf_pkg::COORD_W-1:0]  i_y_pos,
    input  logic                         i_pixel_value,
    input  logic [xsf_pkg::SPRITE_W-1:0] i_sprite_bits,
    input  logic [xsf_pkg::OFF_W-1:0]    i_row_offset,
    input  logic                         i_last_row,
    input  logic                         i_out_stall,
    output logic                         o_out_valid,
    output logic                         o_pixel,
    output logic                         o_collision,
    output logic                         o_sprite_done
);
    import xsf_pkg::*;

    localparam int unsigned EXT_W = SCREEN_COLUMNS + SPRITE_W;
    localparam int unsigned REM_W = 16;

    // row store, rows not written since reset or clear read as blank
    logic [SCREEN_COLUMNS-1:0] r_mem [SCREEN_ROWS];
    logic [SCREEN_ROWS-1:0]    r_row_valid;
    logic [SCREEN_COLUMNS-1:0] r_rd_data;
    logic                      r_rd_valid;

    // captured transaction
    t_op                  r_op;
    logic [COORD_W-1:0]   r_x;
    logic [COORD_W-1:0]   r_q;
    logic [SUM_W-1:0]     r_row;
    logic                 r_val;
    logic [SPRITE_W-1:0]  r_sprite;
    logic                 r_off_zero;
    logic                 r_last;

    logic r_flag;
    logic r_out_valid;
    logic r_pixel;
    logic r_coll;
    logic r_done;

    logic [SUM_W-1:0]          row_sel;
    logic [ROW_AW-1:0]         rd_addr;
    logic [ROW_AW-1:0]         wr_addr;
    logic [PROD_W-1:0]         prod;
    logic [REM_W-1:0]          qc;
    logic [REM_W-1:0]          rem;
    logic [COL_AW-1:0]         x0;
    logic [SPRITE_W-1:0]       rev;
    logic [EXT_W-1:0]          ext;
    logic [SCREEN_COLUMNS-1:0] mask;
    logic [SCREEN_COLUMNS-1:0] row_cur;
    logic [SCREEN_COLUMNS-1:0] row_new;
    logic                      row_ok;
    logic                      col_ok;
    logic                      hit;
    logic                      wr_en;
    logic                      n_flag;
    logic                      n_pixel;
    logic                      n_coll;
    logic                      n_done;

    // address select at load
    always_comb begin
        if (t_op'(i_op) == OP_DRAW) begin
            row_sel = SUM_W'(i_y_pos) + SUM_W'(i_row_offset);
        end else begin
            row_sel = SUM_W'(i_y_pos);
        end
        rd_addr = row_sel[ROW_AW-1:0];
        prod    = PROD_W'(i_x_pos) * PROD_W'(COL_RECIP);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= t_op'(i_op);
            r_x        <= i_x_pos;
            r_q        <= prod[PROD_W-1:RECIP_SHIFT];
            r_row      <= row_sel;
            r_val      <= i_pixel_value;
            r_sprite   <= i_sprite_bits;
            r_off_zero <= (i_row_offset == '0);
            r_last     <= i_last_row;
            r_rd_data  <= r_mem[rd_addr];
            r_rd_valid <= r_row_valid[rd_addr];
        end
    end

    // execute: modify the row read at load
    always_comb begin
        row_cur = r_rd_valid ? r_rd_data : '0;
        row_ok  = (r_row < SUM_W'(SCREEN_ROWS));
        col_ok  = (r_x < COORD_W'(SCREEN_COLUMNS));
        wr_addr = r_row[ROW_AW-1:0];

        qc  = REM_W'(r_q) * REM_W'(SCREEN_COLUMNS);
        rem = REM_W'(r_x) - qc;
        if (rem >= REM_W'(SCREEN_COLUMNS)) begin
            rem = rem - REM_W'(SCREEN_COLUMNS);
        end
        x0 = rem[COL_AW-1:0];

        for (int i = 0; i < SPRITE_W; i++) begin
            rev[i] = r_sprite[SPRITE_W-1-i];
        end
        ext = EXT_W'(rev) << x0;
        // pixels past the right edge fold back to the start of the row
        for (int c = 0; c < SCREEN_COLUMNS; c++) begin
            mask[c] = ext[c];
        end
        for (int j = 0; j < SPRITE_W; j++) begin
            mask[j] = mask[j] | ext[SCREEN_COLUMNS+j];
        end
        hit = row_ok && ((row_cur & mask) != '0);

        row_new = row_cur;
        wr_en   = 1'b0;
        n_flag  = r_flag;
        n_pixel = 1'b0;
        n_coll  = 1'b0;
        n_done  = 1'b0;
        case (r_op)
            OP_CLEAR: begin
                wr_en = 1'b0;
            end
            OP_READ: begin
                n_pixel = row_ok && col_ok && row_cur[r_x[COL_AW-1:0]];
            end
            OP_WRITE: begin
                wr_en = row_ok && col_ok;
                row_new[r_x[COL_AW-1:0]] = r_val;
            end
            OP_DRAW: begin
                wr_en   = row_ok;
                row_new = row_cur ^ mask;
                n_flag  = (r_flag && !r_off_zero) || hit;
                n_coll  = n_flag;
                n_done  = r_last;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) begin
            r_mem[wr_addr] <= row_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_flag      <= 1'b0;
        end else if (i_cmd.exec) begin
            r_flag <= n_flag;
            if (r_op == OP_CLEAR) begin
                r_row_valid <= '0;
            end else if (wr_en) begin
                r_row_valid[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_pixel <= n_pixel;
            r_coll  <= n_coll;
            r_done  <= n_done;
        end
    end

    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_pixel        = r_pixel;
    assign o_collision    = r_coll;
    assign o_sprite_done  = r_done;

endmodule

// ----- rtl/xor_sprite_framebuffer_core.sv -----
`timescale 1ns / 1ps
// a result is registered once the execute state finds the result register free
// one transaction at a time: no new one is taken until the read-modify-write of
// one row word is through (read at accept, modified and written back in S_EXEC)
// clear drops every row valid bit at once
// reset (synchronous, active low) blanks the screen, clears the collision flag
module xor_sprite_framebuffer_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [xsf_pkg::OP_W-1:0]     i_op,
    input  logic [xsf_pkg::COORD_W-1:0]  i_x_pos,
    input  logic [xsf_pkg::COORD_W-1:0]  i_y_pos,
    input  logic                         i_pixel_value,
    input  logic [xsf_pkg::SPRITE_W-1:0] i_sprite_bits,
    input  logic [xsf_pkg::OFF_W-1:0]    i_row_offset,
    input  logic                         i_last_row,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_pixel,
    output logic                         o_collision,
    output logic                         o_sprite_done
);
    import xsf_pkg::*;

    t_cmd    cmd;
    t_status sts;

    xsf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    xsf_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_op          (i_op),
        .i_x_pos       (i_x_pos),
        .i_y_pos       (i_y_pos),
        .i_pixel_value (i_pixel_value),
        .i_sprite_bits (i_sprite_bits),
        .i_row_offset  (i_row_offset),
        .i_last_row    (i_last_row),
        .i_out_stall   (i_stall),
        .o_out_valid   (o_valid),
        .o_pixel       (o_pixel),
        .o_collision   (o_collision),
        .o_sprite_done (o_sprite_done)
    );

endmodule

// ----- rtl/xsf_checker.sv -----
`timescale 1ns / 1ps
module xsf_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_stall,
    input logic [xsf_pkg::OP_W-1:0]     i_op,
    input logic [xsf_pkg::COORD_W-1:0]  i_x_pos,
    input logic [xsf_pkg::COORD_W-1:0]  i_y_pos,
    input logic                         i_pixel_value,
    input logic [xsf_pkg::SPRITE_W-1:0] i_sprite_bits,
    input logic [xsf_pkg::OFF_W-1:0]    i_row_offset,
    input logic                         i_last_row,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic                         o_pixel,
    input logic                         o_collision,
    input logic                         o_sprite_done
);
    import xsf_pkg::*;

    // a waiting result is not dropped
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("result dropped while stalled");

    // one row access in flight: the cycle after an accept is busy
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("transaction accepted during execute");

    // a fresh result comes from the transaction accepted before its execute state
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && !o_stall, 2))
        else $error("result without matching transaction");

    // draw results and read results never mix
    a_field_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_pixel && (o_collision || o_sprite_done)))
        else $error("pixel set on a draw result");

endmodule

bind xor_sprite_framebuffer_core xsf_checker u_xsf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .i_op          (i_op),
    .i_x_pos       (i_x_pos),
    .i_y_pos       (i_y_pos),
    .i_pixel_value (i_pixel_value),
    .i_sprite_bits (i_sprite_bits),
    .i_row_offset  (i_row_offset),
    .i_last_row    (i_last_row),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_pixel       (o_pixel),
    .o_collision   (o_collision),
    .o_sprite_done (o_sprite_done)
);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
    import xsf_pkg::*;

    localparam int N_DIR     = 25;
    localparam int N_RAND    = 1550;
    localparam int CYC_LIMIT = 200000;

    typedef struct packed {
        t_op                 op;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic                val;
        logic [SPRITE_W-1:0] spr;
        logic [OFF_W-1:0]    off;
        logic                last;
    } txn_t;

    typedef struct packed {
        logic pixel;
        logic coll;
        logic done;
    } fb_out_t;

    typedef struct packed {
        txn_t    t;
        logic    known;
        fb_out_t res;
    } dir_row_t;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_valid       = 1'b0;
    logic                o_stall;
    logic [OP_W-1:0]     i_op          = '0;
    logic [COORD_W-1:0]  i_x_pos       = '0;
    logic [COORD_W-1:0]  i_y_pos       = '0;
    logic                i_pixel_value = 1'b0;
    logic [SPRITE_W-1:0] i_sprite_bits = '0;
    logic [OFF_W-1:0]    i_row_offset  = '0;
    logic                i_last_row    = 1'b0;
    logic                o_valid;
    logic                i_stall       = 1'b0;
    logic                o_pixel;
    logic                o_collision;
    logic                o_sprite_done;

    // shadow screen and collision flag
    logic [SCREEN_COLUMNS-1:0] fb_rows [SCREEN_ROWS] = '{default: '0};
    logic                      coll_flag = 1'b0;

    fb_out_t     fb_out_q[$];
    bit          idle_on   = 1'b1;
    int          err_cnt   = 0;
    int          n_checked = 0;
    int          n_sent    = 0;
    int          n_drawn   = 0;
    int unsigned cyc_cnt   = 0;

    // directed transactions; known = 1 rows carry their result, the rest use the shadow
    dir_row_t dir_tab [N_DIR] = '{
        '{'{OP_READ,  8'd0,   8'd0,   1'b0, 8'h00, 4'd0,  1'b0}, 1'b1, 3'b000},
        '{'{OP_READ,  8'd63,  8'd31,  1'b0, 8'h00, 4'd0,  1'b0}, 1'b1, 3'b000},
        '{'{OP_WRITE, 8'd0,   8'd0,   1'b1, 8'h00, 4'd0,  1'b0}, 1'b1, 3'b000},
        '{'{OP_READ,  8'd0,   8'd0,   1'b0, 8'h00, 4'd0,  1'b0}, 1'b1, 3'b100},
        '{'{OP_WRITE, 8'd63,  8'd31,  1'b1, 8'hff, 4'd15, 1'b1}, 1'b1, 3'b000},
        '{'{OP_READ,  8'd63,  8'd31,  1'b0, 8'h00, 4'd0,  1'b0}, 1'b1, 3'b100},
        '{'{OP_READ,  8'd64,  8'd0,   1'b0, 8'h00, 4'd0,  1'b0}, 1'b1, 3'b000},
        '{'{OP_READ,  8'd255, 8'd255, 1'b1, 8'hff, 4'd15, 1'b1}, 1'b1, 3'b000},
        '{'{OP_READ,  8'd0,   8'd32,  1'b0, 8'h00, 4'd0,  1'b0}, 1'b1, 3'b000},
        '{'{OP_WRITE, 8'd200, 8'd5,   1'b1, 8'h00, 4'd0,  1'b0}, 1'b1, 3'b000},
        '{'{OP_READ,  8'd8,   8'd5,   1'b0, 8'h00, 4'd0,  1'b0}, 1'b0, 3'b000},
        '{'{OP_WRITE, 8'd0,   8'd0,   1'b0, 8'h00, 4'd0,  1'b0}, 1'b1, 3'b000},
        '{'{OP_READ,  8'd0,   8'd0,   1'b0, 8'h00, 4'd0,  1'b0}, 1'b0, 3'b000},
        '{'{OP_DRAW,  8'd0,   8'd0,   1'b0, 8'hff, 4'd0,  1'b0}, 1'b0, 3'b000},
        '{'{OP_DRAW,  8'd0,   8'd0,   1'b0, 8'hff, 4'd0,  1'b1}, 1'b0, 3'b000},
        '{'{OP_DRAW,  8'd60,  8'd2,   1'b0, 8'ha5, 4'd0,  1'b0}, 1'b0, 3'b000},
        '{'{OP_DRAW,  8'd255, 8'd10,  1'b0, 8'hff, 4'd3,  1'b1}, 1'b0, 3'b000},
        '{'{OP_DRAW,  8'd0,   8'd31,  1'b0, 8'hff, 4'd1,  1'b0}, 1'b0, 3'b000},
        '{'{OP_DRAW,  8'd255, 8'd255, 1'b1, 8'hff, 4'd15, 1'b1}, 1'b0, 3'b000},
        '{'{OP_DRAW,  8'd0,   8'd40,  1'b0, 8'hff, 4'd0,  1'b0}, 1'b1, 3'b000},
        '{'{OP_DRAW,  8'd5,   8'd4,   1'b0, 8'h80, 4'd0,  1'b0}, 1'b0, 3'b000},
        '{'{OP_DRAW,  8'd5,   8'd3,   1'b0, 8'h80, 4'd1,  1'b0}, 1'b0, 3'b000},
        '{'{OP_CLEAR, 8'd0,   8'd0,   1'b0, 8'h00, 4'd0,  1'b0}, 1'b1, 3'b000},
        '{'{OP_DRAW,  8'd5,   8'd20,  1'b0, 8'h00, 4'd2,  1'b1}, 1'b0, 3'b000},
        '{'{OP_READ,  8'd63,  8'd31,  1'b0, 8'h00, 4'd0,  1'b0}, 1'b1, 3'b000}
    };

    xor_sprite_framebuffer_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_op          (i_op),
        .i_x_pos       (i_x_pos),
        .i_y_pos       (i_y_pos),
        .i_pixel_value (i_pixel_value),
        .i_sprite_bits (i_sprite_bits),
        .i_row_offset  (i_row_offset),
        .i_last_row    (i_last_row),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pixel       (o_pixel),
        .o_collision   (o_collision),
        .o_sprite_done (o_sprite_done)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // applies one operation to the shadow screen and returns what the block should answer
    function automatic fb_out_t xor_fb_apply(input txn_t t);
        fb_out_t                   res;
        int                        row;
        int                        x0;
        logic [SCREEN_COLUMNS-1:0] mask;
        res  = '0;
        mask = '0;
        case (t.op)
            OP_CLEAR: begin
                for (int k = 0; k < SCREEN_ROWS; k++) fb_rows[k] = '0;
            end
            OP_READ: begin
                if (t.x < SCREEN_COLUMNS && t.y < SCREEN_ROWS)
                    res.pixel = fb_rows[int'(t.y)][int'(t.x)];
            end
            OP_WRITE: begin
                if (t.x < SCREEN_COLUMNS && t.y < SCREEN_ROWS)
                    fb_rows[int'(t.y)][int'(t.x)] = t.val;
            end
            default: begin
                row = int'(t.y) + int'(t.off);
                if (t.off == '0) coll_flag = 1'b0;
                if (row < SCREEN_ROWS) begin
                    x0 = int'(t.x) % SCREEN_COLUMNS;
                    // leftmost sprite pixel is the msb, wrapping within the row
                    for (int i = 0; i < SPRITE_W; i++) begin
                        if (t.spr[SPRITE_W-1-i]) mask[(x0 + i) % SCREEN_COLUMNS] = 1'b1;
                    end
                    if ((fb_rows[row] & mask) != '0) coll_flag = 1'b1;
                    fb_rows[row] = fb_rows[row] ^ mask;
                end
                res.coll = coll_flag;
                res.done = t.last;
            end
        endcase
        return res;
    endfunction

    function automatic txn_t rand_txn();
        txn_t t;
        t.op   = t_op'($urandom_range(0, 3));
        t.x    = COORD_W'($urandom_range(0, 255));
        t.y    = COORD_W'($urandom_range(0, 255));
        t.val  = 1'($urandom_range(0, 1));
        t.spr  = SPRITE_W'($urandom_range(0, 255));
        t.off  = OFF_W'($urandom_range(0, 15));
        t.last = 1'($urandom_range(0, 1));
        return t;
    endfunction

    // offers one transaction, waits for it to be taken, records its expected result
    task automatic send_txn(input txn_t t, input logic known, input fb_out_t typed);
        fb_out_t pred;
        while (idle_on && $urandom_range(0, 99) < 27) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_op          <= t.op;
        i_x_pos       <= t.x;
        i_y_pos       <= t.y;
        i_pixel_value <= t.val;
        i_sprite_bits <= t.spr;
        i_row_offset  <= t.off;
        i_last_row    <= t.last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pred = xor_fb_apply(t);
        fb_out_q.push_back(known ? typed : pred);
        n_sent++;
        if (t.op == OP_DRAW) n_drawn++;
    endtask

    always @(posedge i_clk) begin
        i_stall <= idle_on && ($urandom_range(0, 99) < 27);
    end

    always @(posedge i_clk) begin : result_check
        fb_out_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (fb_out_q.size() == 0) begin
                $error("result transaction with nothing expected");
                err_cnt++;
            end else begin
                want = fb_out_q.pop_front();
                n_checked++;
                if (o_pixel !== want.pixel) begin
                    $error("pixel: expected %0d, got %0d", want.pixel, o_pixel);
                    err_cnt++;
                end
                if (o_collision !== want.coll) begin
                    $error("collision: expected %0d, got %0d", want.coll, o_collision);
                    err_cnt++;
                end
                if (o_sprite_done !== want.done) begin
                    $error("sprite_done: expected %0d, got %0d", want.done, o_sprite_done);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt > CYC_LIMIT) begin
            $display("tb_top: timeout with %0d results outstanding", fb_out_q.size());
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial begin
        txn_t t;
        int   sel;
        int   len;
        int   n_rand;
        n_rand = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int d = 0; d < N_DIR; d++) begin
            send_txn(dir_tab[d].t, dir_tab[d].known, dir_tab[d].res);
        end

        while (n_rand < N_RAND) begin
            // a long run with both sides always ready
            idle_on = !(n_rand >= 500 && n_rand < 850);
            sel = $urandom_range(0, 99);
            t   = rand_txn();
            if (sel < 45) begin
                // well formed sprite: offsets 0..len-1, last on the final row
                len = $urandom_range(1, 15);
                if ($urandom_range(0, 9) != 0) begin
                    t.y = COORD_W'($urandom_range(0, SCREEN_ROWS - 1));
                end
                for (int r = 0; r < len; r++) begin
                    t.op   = OP_DRAW;
                    t.off  = OFF_W'(r);
                    t.last = (r == len - 1);
                    t.spr  = SPRITE_W'($urandom_range(0, 255));
                    send_txn(t, 1'b0, '0);
                end
                n_rand += len;
            end else begin
                if (sel < 70) begin
                    t.op = OP_READ;
                end else if (sel < 93) begin
                    t.op = OP_WRITE;
                end else if (sel < 96) begin
                    t.op = OP_CLEAR;
                end
                // anything else keeps the fully random transaction as noise
                if (t.op != OP_DRAW && $urandom_range(0, 99) < 85) begin
                    t.x = COORD_W'($urandom_range(0, SCREEN_COLUMNS - 1));
                    t.y = COORD_W'($urandom_range(0, SCREEN_ROWS - 1));
                end
                send_txn(t, 1'b0, '0);
                n_rand++;
            end
        end
        i_valid <= 1'b0;
        idle_on = 1'b1;

        while (fb_out_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("tb_top: %0d transactions sent (%0d sprite rows), %0d results checked",
                 n_sent, n_drawn, n_checked);
        $display("tb_top: covered clear, pixel read/write on and off screen, wrap and collision");
        if (err_cnt == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
